// ----- rtl/crv_pkg.sv -----
// types and constants shared by the response validator files
`default_nettype none

package crv_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned COUNT_W     = 5;
   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 64;

   localparam logic [COUNT_W-1:0] HEADER_BYTES      = 5'd4;
   localparam logic [COUNT_W-1:0] HEADER_LAST_INDEX = 5'd3;
   localparam logic [COUNT_W-1:0] COUNT_MAX         = 5'd31;

   localparam logic [2:0] CLASS_SUCCESS      = 3'd2;
   localparam logic [2:0] CLASS_CLIENT_ERROR = 3'd4;
   localparam logic [2:0] CLASS_SERVER_ERROR = 3'd5;

   typedef enum logic [1:0] {
      MSG_CON = 2'd0,
      MSG_NON = 2'd1,
      MSG_ACK = 2'd2,
      MSG_RST = 2'd3
   } msg_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_VERSION      = 4'd0,
      REG_TOKEN_LENGTH = 4'd1,
      REG_MESSAGE_ID   = 4'd2,
      REG_TOKEN        = 4'd3
   } reg_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              last_byte;
   } request_type;

   typedef struct packed {
      logic              invalid;
      logic              is_ack;
      logic              piggybacked;
      logic              separate;
      logic              need_send_ack;
      logic              is_reset;
      logic              success_class;
      logic              failure_class;
      logic [BYTE_W-1:0] response_code;
   } result_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

endpackage

`default_nettype wire

// ----- rtl/crv_stream_if.sv -----
// valid/ready channel interface with a typed payload
`default_nettype none

interface crv_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/crv_out_buffer.sv -----
// result register with a skid stage in front of the response channel
`default_nettype none

module crv_out_buffer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire crv_pkg::result_type in_data,
   output logic                    in_ready,
   crv_stream_if.source            rsp_if
);
   import crv_pkg::*;

   logic       main_valid_ff;
   logic       skid_valid_ff;
   result_type main_ff;
   result_type skid_ff;

   assign in_ready       = !skid_valid_ff;
   assign rsp_if.valid   = main_valid_ff;
   assign rsp_if.payload = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!main_valid_ff || rsp_if.ready) begin
         if (skid_valid_ff) begin
            main_ff       <= skid_ff;
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_ff       <= in_data;
            main_valid_ff <= in_valid;
         end
      end else if (in_valid) begin
         skid_ff       <= in_data;
         skid_valid_ff <= 1'b1;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/coap_response_validator.sv -----
// coap response validator: one verdict per datagram, one request byte per cycle
// while the skid stage is empty; the verdict of the last byte is registered in
// the result register, or in the skid stage while that register is stalled;
// together they keep bytes flowing while one verdict waits to be taken
// reset: synchronous; packet state clears, request registers take reset values
`default_nettype none

module coap_response_validator #(
   parameter int unsigned MAX_TOKEN_BYTES = 8
) (
   input  wire logic    clock,
   input  wire logic    reset,
   crv_stream_if.sink   req_if,
   crv_stream_if.sink   csr_if,
   crv_stream_if.source rsp_if
);
   import crv_pkg::*;

   localparam int unsigned TIDX_W = (MAX_TOKEN_BYTES > 1) ? $clog2(MAX_TOKEN_BYTES) : 1;

   logic [1:0]        req_version_ff;
   logic [3:0]        req_token_length_ff;
   logic [15:0]       req_message_id_ff;
   logic [BYTE_W-1:0] req_token_ff [MAX_TOKEN_BYTES];

   logic [COUNT_W-1:0] count_ff,      count_in;
   logic [BYTE_W-1:0]  first_byte_ff, first_byte_in;
   logic [BYTE_W-1:0]  code_ff,       code_in;
   logic [15:0]        mid_ff,        mid_in;
   logic               match_ff,      match_in;

   request_type   req;
   csr_write_type csr;
   logic          accept;
   logic          buf_ready;
   logic [COUNT_W-1:0] tok_pos;
   logic [TIDX_W-1:0]  tok_idx;
   result_type    verdict;

   logic [1:0]   vers;
   msg_kind_type kind;
   logic [3:0]   tkl;
   logic [2:0]   cls;
   logic         ok;

   assign req          = req_if.payload;
   assign csr          = csr_if.payload;
   assign req_if.ready = buf_ready && !reset;
   assign csr_if.ready = !reset;
   assign accept       = req_if.valid && buf_ready && !reset;
   assign tok_pos      = count_ff - HEADER_BYTES;
   assign tok_idx      = tok_pos[TIDX_W-1:0];

   // packet state update for the incoming byte
   always_comb begin
      first_byte_in = first_byte_ff;
      code_in       = code_ff;
      mid_in        = mid_ff;
      match_in      = match_ff;
      if (count_ff == 5'd0) begin
         first_byte_in = req.rx_byte;
      end else if (count_ff == 5'd1) begin
         code_in = req.rx_byte;
      end else if (count_ff == 5'd2) begin
         mid_in[15:8] = req.rx_byte;
      end else if (count_ff == HEADER_LAST_INDEX) begin
         mid_in[7:0] = req.rx_byte;
      end else if (tok_pos < {1'b0, first_byte_ff[3:0]}) begin
         if (tok_pos < COUNT_W'(MAX_TOKEN_BYTES)) begin
            if (req_token_ff[tok_idx] != req.rx_byte) begin
               match_in = 1'b0;
            end
         end else begin
            match_in = 1'b0;
         end
      end
      count_in = (count_ff < COUNT_MAX) ? count_ff + 5'd1 : COUNT_MAX;
   end

   // verdict from the updated packet state
   always_comb begin
      vers    = first_byte_in[7:6];
      kind    = msg_kind_type'(first_byte_in[5:4]);
      tkl     = first_byte_in[3:0];
      cls     = code_in[7:5];
      ok      = 1'b1;
      verdict = '0;
      if (count_in < HEADER_BYTES || vers != req_version_ff) begin
         ok = 1'b0;
      end else if (kind == MSG_RST) begin
         if (code_in == 8'd0 && tkl == 4'd0 && count_in == HEADER_BYTES) begin
            verdict.is_reset = 1'b1;
         end else begin
            ok = 1'b0;
         end
      end else if (kind == MSG_ACK && mid_in != req_message_id_ff) begin
         ok = 1'b0;
      end else if (kind == MSG_ACK && code_in == 8'd0) begin
         if (tkl == 4'd0 && count_in == HEADER_BYTES) begin
            verdict.is_ack = 1'b1;
         end else begin
            ok = 1'b0;
         end
      end else begin
         if (kind == MSG_ACK) begin
            verdict.is_ack      = 1'b1;
            verdict.piggybacked = 1'b1;
         end else begin
            verdict.separate = 1'b1;
            if (kind == MSG_CON) begin
               verdict.need_send_ack = 1'b1;
            end
            if (mid_in == req_message_id_ff) begin
               ok = 1'b0;
            end
         end
         if (tkl != req_token_length_ff) begin
            ok = 1'b0;
         end
         if ({1'b0, count_in} < {1'b0, HEADER_BYTES} + {2'b00, tkl}) begin
            ok = 1'b0;
         end
         if (!match_in) begin
            ok = 1'b0;
         end
         if (cls == CLASS_SUCCESS) begin
            verdict.success_class = 1'b1;
         end else if (cls inside {CLASS_CLIENT_ERROR, CLASS_SERVER_ERROR}) begin
            verdict.failure_class = 1'b1;
         end else begin
            ok = 1'b0;
         end
      end
      if (ok) begin
         verdict.response_code = code_in;
      end else begin
         verdict         = '0;
         verdict.invalid = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         first_byte_ff <= '0;
         code_ff       <= '0;
         mid_ff        <= '0;
         match_ff      <= 1'b1;
      end else if (accept) begin
         if (req.last_byte) begin
            count_ff      <= '0;
            first_byte_ff <= '0;
            code_ff       <= '0;
            mid_ff        <= '0;
            match_ff      <= 1'b1;
         end else begin
            count_ff      <= count_in;
            first_byte_ff <= first_byte_in;
            code_ff       <= code_in;
            mid_ff        <= mid_in;
            match_ff      <= match_in;
         end
      end
   end

   // request registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_version_ff      <= 2'd1;
         req_token_length_ff <= '0;
         req_message_id_ff   <= '0;
         for (int i = 0; i < MAX_TOKEN_BYTES; i++) begin
            req_token_ff[i] <= '0;
         end
      end else if (csr_if.valid) begin
         case (csr.index)
            REG_VERSION:      req_version_ff      <= csr.data[1:0];
            REG_TOKEN_LENGTH: req_token_length_ff <= csr.data[3:0];
            REG_MESSAGE_ID:   req_message_id_ff   <= csr.data[15:0];
            REG_TOKEN: begin
               for (int i = 0; i < MAX_TOKEN_BYTES; i++) begin
                  req_token_ff[i] <= csr.data[i*BYTE_W +: BYTE_W];
               end
            end
            default: ;
         endcase
      end
   end

   crv_out_buffer u_out_buffer (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept && req.last_byte),
      .in_data  (verdict),
      .in_ready (buf_ready),
      .rsp_if   (rsp_if)
   );

endmodule

`default_nettype wire

// ----- verif/tb_coap_response_validator.sv -----
// self-checking testbench for the coap response validator: directed table, then random datagrams
module tb_coap_response_validator;
   timeunit 1ns;
   timeprecision 1ps;

   import crv_pkg::*;

   localparam int unsigned TOKEN_SLOTS  = 8;
   localparam int unsigned IDLE_PCT     = 18;
   localparam int unsigned RANDOM_BYTES = 1050;
   localparam int unsigned PHASE_PKTS   = 20;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned CYCLE_LIMIT  = 200000;

   localparam logic [7:0] F_INVALID  = 8'b1000_0000;
   localparam logic [7:0] F_ACK      = 8'b0100_0000;
   localparam logic [7:0] F_PIGGY    = 8'b0010_0000;
   localparam logic [7:0] F_SEPARATE = 8'b0001_0000;
   localparam logic [7:0] F_NEED_ACK = 8'b0000_1000;
   localparam logic [7:0] F_RESET    = 8'b0000_0100;
   localparam logic [7:0] F_SUCCESS  = 8'b0000_0010;
   localparam logic [7:0] F_FAILURE  = 8'b0000_0001;

   typedef struct {
      logic [7:0]  head;
      logic [7:0]  code;
      logic [15:0] mid;
      int unsigned len;
      bit          bad_token;
      bit          typed;
      result_type  want;
   } dir_row_type;

   logic clock;
   logic reset;

   crv_stream_if #(.payload_type(request_type))   req_ch ();
   crv_stream_if #(.payload_type(csr_write_type)) csr_ch ();
   crv_stream_if #(.payload_type(result_type))    rsp_ch ();

   coap_response_validator #(
      .MAX_TOKEN_BYTES(TOKEN_SLOTS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch),
      .csr_if(csr_ch),
      .rsp_if(rsp_ch)
   );

   // request registers as the block should hold them
   logic [1:0]  cfg_version;
   logic [3:0]  cfg_token_len;
   logic [15:0] cfg_mid;
   logic [63:0] cfg_token;

   // datagram being assembled
   logic [4:0]  pk_count;
   logic [7:0]  pk_head;
   logic [7:0]  pk_code;
   logic [15:0] pk_mid;
   logic        pk_token_ok;

   result_type   verdicts_due[$];
   logic [7:0]   packet[$];
   dir_row_type  dir_rows[$];

   int unsigned  idle_pct;
   int unsigned  mismatches;
   int unsigned  cycle_count;
   int unsigned  bytes_sent;
   bit           hold_go;
   logic         holding;

   always #4 clock = ~clock;

   function automatic result_type make_verdict(input logic [7:0] flags, input logic [7:0] code);
      return {flags, code};
   endfunction

   function automatic void clear_datagram();
      pk_count    = '0;
      pk_head     = '0;
      pk_code     = '0;
      pk_mid      = '0;
      pk_token_ok = 1'b1;
   endfunction

   // advances the datagram state by one byte; returns 1 with a verdict on a last byte
   function automatic bit judge_byte(input logic [7:0] b, input logic last,
                                     output result_type r);
      logic [4:0]   pos;
      logic [1:0]   ver;
      msg_kind_type kind;
      logic [3:0]   tkl;
      logic [2:0]   cls;
      logic         ok;
      int unsigned  k;
      r   = '0;
      ok  = 1'b1;
      pos = pk_count;
      if (pos == 0) begin
         pk_head = b;
      end else if (pos == 1) begin
         pk_code = b;
      end else if (pos == 2) begin
         pk_mid[15:8] = b;
      end else if (pos == HEADER_LAST_INDEX) begin
         pk_mid[7:0] = b;
      end else begin
         k = int'(pos) - int'(HEADER_BYTES);
         if (k < pk_head[3:0]) begin
            if (k < TOKEN_SLOTS) begin
               if (b != cfg_token[8*k +: 8]) pk_token_ok = 1'b0;
            end else begin
               pk_token_ok = 1'b0;
            end
         end
      end
      pk_count = (pos < COUNT_MAX) ? pos + 5'd1 : COUNT_MAX;
      if (!last) return 1'b0;

      ver  = pk_head[7:6];
      kind = msg_kind_type'(pk_head[5:4]);
      tkl  = pk_head[3:0];
      cls  = pk_code[7:5];
      if (pk_count < HEADER_BYTES || ver != cfg_version) begin
         ok = 1'b0;
      end else if (kind == MSG_RST) begin
         if (pk_code == 8'd0 && tkl == 4'd0 && pk_count == HEADER_BYTES) r.is_reset = 1'b1;
         else ok = 1'b0;
      end else if (kind == MSG_ACK && pk_mid != cfg_mid) begin
         ok = 1'b0;
      end else if (kind == MSG_ACK && pk_code == 8'd0) begin
         if (tkl == 4'd0 && pk_count == HEADER_BYTES) r.is_ack = 1'b1;
         else ok = 1'b0;
      end else begin
         if (kind == MSG_ACK) begin
            r.is_ack      = 1'b1;
            r.piggybacked = 1'b1;
         end else begin
            r.separate = 1'b1;
            if (kind == MSG_CON) r.need_send_ack = 1'b1;
            if (pk_mid == cfg_mid) ok = 1'b0;
         end
         if (tkl != cfg_token_len) ok = 1'b0;
         if (int'(pk_count) < int'(HEADER_BYTES) + int'(tkl)) ok = 1'b0;
         if (!pk_token_ok) ok = 1'b0;
         if (cls == CLASS_SUCCESS) r.success_class = 1'b1;
         else if (cls == CLASS_CLIENT_ERROR || cls == CLASS_SERVER_ERROR) r.failure_class = 1'b1;
         else ok = 1'b0;
      end
      if (ok) r.response_code = pk_code;
      else r = make_verdict(F_INVALID, 8'h00);
      clear_datagram();
      return 1'b1;
   endfunction

   task automatic check_verdict(input result_type got);
      result_type want;
      if (verdicts_due.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected verdict %b code %h", got[15:8], got.response_code);
      end else begin
         want = verdicts_due.pop_front();
         if (got.invalid !== want.invalid || got.is_ack !== want.is_ack ||
             got.piggybacked !== want.piggybacked || got.separate !== want.separate ||
             got.need_send_ack !== want.need_send_ack || got.is_reset !== want.is_reset ||
             got.success_class !== want.success_class ||
             got.failure_class !== want.failure_class ||
             got.response_code !== want.response_code) begin
            mismatches++;
            if (mismatches <= 10)
               $display("verdict flags exp %b got %b, code exp %h got %h",
                        want[15:8], got[15:8], want.response_code, got.response_code);
         end
      end
   endtask

   // response side: random back-pressure plus one long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) check_verdict(rsp_ch.payload);
         rsp_ch.ready <= !holding && ($urandom_range(99) >= idle_pct);
      end
   end

   initial begin
      holding = 1'b0;
      wait (hold_go);
      @(posedge clock);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      holding <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("coap_response_validator: mismatch");
         $finish;
      end
   end

   task automatic csr_write(input reg_index_type idx, input logic [63:0] data);
      csr_ch.valid         <= 1'b1;
      csr_ch.payload.index <= idx;
      csr_ch.payload.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         REG_VERSION:      cfg_version   = data[1:0];
         REG_TOKEN_LENGTH: cfg_token_len = data[3:0];
         REG_MESSAGE_ID:   cfg_mid       = data[15:0];
         REG_TOKEN:        cfg_token     = data;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [1:0] ver, input logic [3:0] tkl,
                            input logic [15:0] mid, input logic [63:0] token);
      csr_write(REG_VERSION, {62'd0, ver});
      csr_write(REG_TOKEN_LENGTH, {60'd0, tkl});
      csr_write(REG_MESSAGE_ID, {48'd0, mid});
      csr_write(REG_TOKEN, token);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic send_request(input logic [7:0] b, input logic last,
                               input bit typed, input result_type want);
      result_type r;
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid             <= 1'b1;
      req_ch.payload.rx_byte   <= b;
      req_ch.payload.last_byte <= last;
      do @(posedge clock); while (!req_ch.ready);
      bytes_sent++;
      if (judge_byte(b, last, r)) verdicts_due.push_back(typed ? want : r);
   endtask

   task automatic send_packet(input bit typed, input result_type want);
      for (int i = 0; i < packet.size(); i++)
         send_request(packet[i], i == packet.size() - 1, typed, want);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_row(input logic [7:0] head, input logic [7:0] code, input logic [15:0] mid,
                          input int unsigned len, input bit bad_token, input bit typed,
                          input result_type want);
      dir_row_type row;
      row.head      = head;
      row.code      = code;
      row.mid       = mid;
      row.len       = len;
      row.bad_token = bad_token;
      row.typed     = typed;
      row.want      = want;
      dir_rows.push_back(row);
   endtask

   task automatic build_row_packet(input dir_row_type row);
      logic [7:0]  tok;
      int unsigned k;
      packet.delete();
      for (int unsigned pos = 0; pos < row.len; pos++) begin
         case (pos)
            0: packet.push_back(row.head);
            1: packet.push_back(row.code);
            2: packet.push_back(row.mid[15:8]);
            3: packet.push_back(row.mid[7:0]);
            default: begin
               k = pos - 4;
               if (k < row.head[3:0] && k < TOKEN_SLOTS) begin
                  tok = cfg_token[8*k +: 8];
                  if (row.bad_token && k == 0) tok = ~tok;
               end else begin
                  tok = pos[0] ? 8'hFF : 8'h00;
               end
               packet.push_back(tok);
            end
         endcase
      end
   endtask

   task automatic build_random_packet();
      int unsigned  kind;
      int unsigned  mut;
      int unsigned  extra;
      int unsigned  cut;
      logic [1:0]   ver;
      msg_kind_type ty;
      logic [3:0]   tkl;
      logic [2:0]   cls;
      logic [7:0]   code;
      logic [15:0]  mid;
      logic [7:0]   tok;
      packet.delete();
      kind  = $urandom_range(4);
      ver   = cfg_version;
      tkl   = (kind < 2) ? 4'd0 : cfg_token_len;
      extra = 0;
      case ($urandom_range(2))
         0: cls = CLASS_SUCCESS;
         1: cls = CLASS_CLIENT_ERROR;
         default: cls = CLASS_SERVER_ERROR;
      endcase
      code = (kind < 2) ? 8'd0 : {cls, 5'($urandom_range(31))};
      case (kind)
         0: begin ty = MSG_ACK; mid = cfg_mid; end
         1: begin ty = MSG_RST; mid = 16'($urandom); end
         2: begin ty = MSG_ACK; mid = cfg_mid; end
         3: begin ty = MSG_CON; mid = cfg_mid ^ 16'($urandom_range(1, 65535)); end
         default: begin ty = MSG_NON; mid = cfg_mid ^ 16'($urandom_range(1, 65535)); end
      endcase
      if (kind >= 2) extra = ($urandom_range(19) == 0) ? $urandom_range(30) : $urandom_range(3);
      mut = ($urandom_range(3) == 0) ? $urandom_range(7) : 8;
      case (mut)
         0: ver = ver ^ 2'($urandom_range(1, 3));
         1: tkl = 4'($urandom_range(15));
         3: mid = mid ^ (16'd1 << $urandom_range(15));
         4: code = 8'($urandom);
         7: ty = msg_kind_type'($urandom_range(3));
         default: ;
      endcase
      packet.push_back({ver, ty, tkl});
      packet.push_back(code);
      packet.push_back(mid[15:8]);
      packet.push_back(mid[7:0]);
      for (int unsigned k = 0; k < tkl; k++) begin
         tok = (k < TOKEN_SLOTS) ? cfg_token[8*k +: 8] : 8'($urandom);
         if (mut == 2 && k == 0) tok = tok ^ 8'($urandom_range(1, 255));
         packet.push_back(tok);
      end
      if (mut == 2 && tkl == 0) packet[1] = 8'($urandom);
      for (int unsigned i = 0; i < extra; i++) packet.push_back(8'($urandom));
      if (mut == 5 && packet.size() > 1) begin
         cut = $urandom_range(1, packet.size() - 1);
         while (packet.size() > cut) void'(packet.pop_back());
      end
      if (mut == 6) begin
         packet.delete();
         cut = $urandom_range(1, 12);
         for (int unsigned i = 0; i < cut; i++) packet.push_back(8'($urandom));
      end
   endtask

   initial begin
      int unsigned phase;
      logic [1:0]  ver;
      logic [3:0]  tkl;
      logic [15:0] mid;
      logic [63:0] token;
      clock                    = 1'b0;
      reset                    = 1'b1;
      req_ch.valid             = 1'b0;
      req_ch.payload           = '0;
      csr_ch.valid             = 1'b0;
      csr_ch.payload           = '0;
      rsp_ch.ready             = 1'b0;
      idle_pct                 = IDLE_PCT;
      mismatches               = 0;
      cycle_count              = 0;
      bytes_sent               = 0;
      hold_go                  = 1'b0;
      cfg_version              = 2'd1;
      cfg_token_len            = 4'd0;
      cfg_mid                  = 16'd0;
      cfg_token                = 64'd0;
      clear_datagram();

      // request: version 1, two token bytes 5a a5, message id 1234
      add_row(8'h60, 8'h00, 16'h1234, 1, 0, 1, make_verdict(F_INVALID, 8'h00));
      add_row(8'h60, 8'h00, 16'h1234, 3, 0, 1, make_verdict(F_INVALID, 8'h00));
      add_row(8'h60, 8'h00, 16'h1234, 4, 0, 1, make_verdict(F_ACK, 8'h00));
      add_row(8'h70, 8'h00, 16'hFFFF, 4, 0, 1, make_verdict(F_RESET, 8'h00));
      add_row(8'h62, 8'h45, 16'h1234, 6, 0, 1, make_verdict(F_ACK | F_PIGGY | F_SUCCESS, 8'h45));
      add_row(8'h42, 8'h84, 16'h0000, 8, 0, 1,
              make_verdict(F_SEPARATE | F_NEED_ACK | F_FAILURE, 8'h84));
      add_row(8'h52, 8'hBF, 16'hFFFF, 6, 0, 1, make_verdict(F_SEPARATE | F_FAILURE, 8'hBF));
      add_row(8'h62, 8'h45, 16'h1234, 6, 1, 1, make_verdict(F_INVALID, 8'h00));
      add_row(8'hE2, 8'h45, 16'h1234, 6, 0, 1, make_verdict(F_INVALID, 8'h00));
      add_row(8'h62, 8'h45, 16'h1235, 6, 0, 1, make_verdict(F_INVALID, 8'h00));
      add_row(8'h42, 8'h45, 16'h1234, 6, 0, 1, make_verdict(F_INVALID, 8'h00));
      add_row(8'h42, 8'h60, 16'h0001, 6, 0, 1, make_verdict(F_INVALID, 8'h00));
      add_row(8'h62, 8'h45, 16'h1234, 5, 0, 1, make_verdict(F_INVALID, 8'h00));
      add_row(8'h60, 8'h00, 16'h1234, 5, 0, 1, make_verdict(F_INVALID, 8'h00));
      add_row(8'h71, 8'h00, 16'h1234, 5, 0, 1, make_verdict(F_INVALID, 8'h00));
      add_row(8'h70, 8'h01, 16'h1234, 4, 0, 1, make_verdict(F_INVALID, 8'h00));
      add_row(8'h52, 8'h5F, 16'h0F0F, 40, 0, 0, '0);
      add_row(8'h4F, 8'h45, 16'h0002, 24, 0, 1, make_verdict(F_INVALID, 8'h00));
      add_row(8'h00, 8'h00, 16'h0000, 4, 0, 1, make_verdict(F_INVALID, 8'h00));
      add_row(8'hFF, 8'hFF, 16'hFFFF, 4, 0, 1, make_verdict(F_INVALID, 8'h00));
      add_row(8'h62, 8'hA0, 16'h1234, 10, 0, 0, '0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      configure(2'd1, 4'd2, 16'h1234, 64'h0123_4567_89AB_A55A);
      foreach (dir_rows[i]) begin
         build_row_packet(dir_rows[i]);
         send_packet(dir_rows[i].typed, dir_rows[i].want);
      end

      bytes_sent = 0;
      phase      = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         wait_idle();
         ver   = 2'($urandom_range(3));
         tkl   = 4'($urandom_range(8));
         mid   = 16'($urandom);
         token = {$urandom, $urandom};
         case (phase)
            0: begin ver = 2'd0; tkl = 4'd0; mid = 16'h0000; token = '0; end
            1: begin ver = 2'd3; tkl = 4'd8; mid = 16'hFFFF; token = '1; end
            5: tkl = 4'd12;
            default: ;
         endcase
         configure(ver, tkl, mid, token);
         idle_pct = (phase == 2) ? 0 : IDLE_PCT;
         if (phase == 3) hold_go = 1'b1;
         for (int unsigned n = 0; n < PHASE_PKTS; n++) begin
            build_random_packet();
            send_packet(0, '0);
         end
         phase++;
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && verdicts_due.size() == 0) begin
         $display("coap_response_validator: match");
      end else begin
         $display("coap_response_validator: mismatch");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/crv_pkg.sv
rtl/crv_stream_if.sv
rtl/crv_out_buffer.sv
rtl/coap_response_validator.sv
verif/tb_coap_response_validator.sv
